>>> rtl/tx_cell_pdr_relocation_tracker_core_defines.svh
// Assertion macros used by the tracker RTL.
`ifndef TX_CELL_PDR_RELOCATION_TRACKER_CORE_DEFINES_SVH
`define TX_CELL_PDR_RELOCATION_TRACKER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TCPRT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TCPRT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/tcprt_pkg.sv
// Package with payload types, codes and constants of the cell tracker.
package tcprt_pkg;
    localparam int MaxCells = 16;
    localparam int IdxW = $clog2(MaxCells);
    localparam int CntW = $clog2(MaxCells + 1);

    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_REMOVE  = 3'd1;
    localparam logic [2:0] FUNC_REPORT  = 3'd2;
    localparam logic [2:0] FUNC_PROPOSE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [0:0] CFG_MIN_TX = 1'd0;
    localparam logic [0:0] CFG_MARGIN = 1'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] slot;
        logic [7:0]  chan;
        logic [7:0]  tx_attempts;
        logic        tx_acked;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] cell_slot;
        logic [7:0]  cell_channel;
        logic [4:0]  cell_count;
    } t_out_item;

    // Request to the divider and its answer.
    typedef struct packed {
        logic        start;
        logic [14:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [14:0] quotient;
    } t_div_rsp;
endpackage

>>> rtl/tcprt_div.sv
// Restoring divider, one quotient bit per cycle.
module tcprt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcprt_pkg::t_div_req i_req,
    output tcprt_pkg::t_div_rsp o_rsp
);
    import tcprt_pkg::*;

    logic [14:0] r_quo, n_quo;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_dvs;
    logic [3:0]  r_cnt;
    logic        r_busy, r_done;
    logic [8:0]  trial;

    always_comb begin
        trial = {r_rem, r_quo[14]} - {1'b0, r_dvs};
        n_quo = {r_quo[13:0], 1'b0};
        n_rem = {r_rem[6:0], r_quo[14]};
        if (!trial[8]) begin
            n_quo[0] = 1'b1;
            n_rem = trial[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= 4'd0;
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dvs <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The 9-bit trial keeps the carry; remainder never exceeds the divisor.
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> rtl/tx_cell_pdr_relocation_tracker_core.sv
// Top level of the transmit-cell delivery-ratio tracker.
//
//  Channel | Direction | Handshake              | Payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One transfer at a time: an add or remove walks the table one entry per
// cycle, a report walks one attempt per cycle and a propose runs each
// eligible entry in turn through the bit-serial divider.
// Reset is synchronous, clears the entry count and sets the configuration
// registers to their defaults; the input is stalled while reset is held.
// The input is stalled while an item is at work or its result waits;
// a stalled result holds until the transfer completes.
module tx_cell_pdr_relocation_tracker_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcprt_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcprt_pkg::t_out_item  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import tcprt_pkg::*;
    `include "tx_cell_pdr_relocation_tracker_core_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_SHIFT, S_WRITE, S_REM_FIND, S_REM_SHIFT,
        S_REP_FIND, S_REP_ACK, S_REP_WALK, S_PR_LOOK, S_PR_WAIT, S_DONE
    } t_state;

    t_state      r_state;
    t_in_item    r_item;
    t_out_item   r_out;
    logic [7:0]  r_min_tx;
    logic [6:0]  r_margin;
    logic [CntW-1:0] r_total;
    logic [CntW-1:0] r_i;
    logic [IdxW-1:0] r_cur, r_worst;
    logic [7:0]  r_att;
    logic [14:0] r_best, r_low;
    logic        r_any;

    logic [15:0] r_slot [MaxCells];
    logic [7:0]  r_chan [MaxCells];
    logic [7:0]  r_tx   [MaxCells];
    logic [7:0]  r_ack  [MaxCells];

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [IdxW-1:0] i_idx, prev_idx, next_idx;
    logic [14:0] diff;
    t_out_item   idle_out;

    tcprt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign i_idx = r_i[IdxW-1:0];
    assign prev_idx = i_idx - IdxW'(1);
    assign next_idx = i_idx + IdxW'(1);
    assign diff = r_best - r_low;

    always_comb begin
        div_req.start = (r_state == S_PR_LOOK) && (r_i < r_total) &&
                        (r_tx[i_idx] != 8'd0) && (r_tx[i_idx] >= r_min_tx);
        div_req.dividend = 15'(r_ack[i_idx]) * 15'd100;
        div_req.divisor = r_tx[i_idx];
    end

    // Result fields already known when an item is taken; later states fill in the rest.
    always_comb begin
        idle_out = '0;
        idle_out.cell_count = 5'(r_total);
        case (i_in_data.func)
            FUNC_ADD: begin
                if (r_total >= CntW'(MaxCells)) begin
                    idle_out.status = ST_FULL;
                end
            end
            FUNC_CLEAR: idle_out.cell_count = '0;
            default: ;
        endcase
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_min_tx <= 8'd128;
            r_margin <= 7'd50;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_TX: r_min_tx <= i_cfg_data;
                    CFG_MARGIN: r_margin <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_out <= idle_out;
                        r_i <= '0;
                        r_any <= 1'b0;
                        case (i_in_data.func)
                            FUNC_ADD: begin
                                if (r_total >= CntW'(MaxCells)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_FIND;
                                end
                            end
                            FUNC_REMOVE:  r_state <= S_REM_FIND;
                            FUNC_REPORT:  r_state <= S_REP_FIND;
                            FUNC_PROPOSE: r_state <= S_PR_LOOK;
                            FUNC_CLEAR: begin
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_i < r_total && r_slot[i_idx] >= r_item.slot) begin
                        r_i <= r_i + CntW'(1);
                    end else begin
                        r_cur <= i_idx;
                        r_i <= r_total;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // Shift entries up by one from the tail down to the slot found.
                    if (i_idx != r_cur) begin
                        r_slot[i_idx] <= r_slot[prev_idx];
                        r_chan[i_idx] <= r_chan[prev_idx];
                        r_tx[i_idx] <= r_tx[prev_idx];
                        r_ack[i_idx] <= r_ack[prev_idx];
                        r_i <= r_i - CntW'(1);
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_slot[r_cur] <= r_item.slot;
                    r_chan[r_cur] <= r_item.chan;
                    r_tx[r_cur] <= '0;
                    r_ack[r_cur] <= '0;
                    r_total <= r_total + CntW'(1);
                    r_out.cell_count <= 5'(r_total + CntW'(1));
                    r_state <= S_DONE;
                end
                S_REM_FIND: begin
                    if (r_i >= r_total) begin
                        r_out.status <= ST_NOTFOUND;
                        r_state <= S_DONE;
                    end else if (r_slot[i_idx] == r_item.slot &&
                                 r_chan[i_idx] == r_item.chan) begin
                        r_state <= S_REM_SHIFT;
                    end else begin
                        r_i <= r_i + CntW'(1);
                    end
                end
                S_REM_SHIFT: begin
                    if (r_i + CntW'(1) < r_total) begin
                        r_slot[i_idx] <= r_slot[next_idx];
                        r_chan[i_idx] <= r_chan[next_idx];
                        r_tx[i_idx] <= r_tx[next_idx];
                        r_ack[i_idx] <= r_ack[next_idx];
                        r_i <= r_i + CntW'(1);
                    end else begin
                        r_total <= r_total - CntW'(1);
                        r_out.cell_count <= 5'(r_total - CntW'(1));
                        r_state <= S_DONE;
                    end
                end
                S_REP_FIND: begin
                    if (r_total == '0) begin
                        r_out.status <= ST_NOTFOUND;
                        r_state <= S_DONE;
                    end else if (r_i < r_total) begin
                        if (r_slot[i_idx] <= r_item.slot) begin
                            r_att <= r_item.tx_attempts;
                            r_cur <= i_idx;
                            r_state <= S_REP_ACK;
                        end else begin
                            r_i <= r_i + CntW'(1);
                        end
                    end else if (r_item.tx_attempts <= 8'd1) begin
                        r_out.status <= ST_NOTFOUND;
                        r_state <= S_DONE;
                    end else begin
                        r_att <= r_item.tx_attempts - 8'd1;
                        r_cur <= '0;
                        r_state <= S_REP_ACK;
                    end
                end
                S_REP_ACK: begin
                    if (r_item.tx_acked && r_ack[r_cur] != 8'd255) begin
                        r_ack[r_cur] <= r_ack[r_cur] + 8'd1;
                    end
                    r_state <= S_REP_WALK;
                end
                S_REP_WALK: begin
                    if (r_att == 8'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_tx[r_cur] == 8'd255) begin
                            r_tx[r_cur] <= 8'd128;
                            r_ack[r_cur] <= {1'b0, r_ack[r_cur][7:1]};
                        end else begin
                            r_tx[r_cur] <= r_tx[r_cur] + 8'd1;
                        end
                        r_att <= r_att - 8'd1;
                        if (CntW'(r_cur) + CntW'(1) >= r_total) begin
                            r_cur <= '0;
                        end else begin
                            r_cur <= r_cur + IdxW'(1);
                        end
                    end
                end
                S_PR_LOOK: begin
                    if (r_i >= r_total) begin
                        if (r_any && diff > 15'(r_margin)) begin
                            r_out <= '{status: r_out.status, found: 1'b1,
                                       cell_slot: r_slot[r_worst],
                                       cell_channel: r_chan[r_worst],
                                       cell_count: r_out.cell_count};
                        end
                        r_state <= S_DONE;
                    end else if (div_req.start) begin
                        r_state <= S_PR_WAIT;
                    end else begin
                        r_i <= r_i + CntW'(1);
                    end
                end
                S_PR_WAIT: begin
                    if (div_rsp.done) begin
                        if (!r_any || div_rsp.quotient > r_best) begin
                            r_best <= div_rsp.quotient;
                        end
                        if (!r_any || div_rsp.quotient < r_low) begin
                            r_low <= div_rsp.quotient;
                            r_worst <= i_idx;
                        end
                        r_any <= 1'b1;
                        r_i <= r_i + CntW'(1);
                        r_state <= S_PR_LOOK;
                    end
                end
                S_DONE: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TCPRT_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_total <= CntW'(MaxCells))
    `TCPRT_ASSERT_IMP(a_div_only_propose, i_clk, i_rst_n, div_req.start, r_state == S_PR_LOOK)
    `TCPRT_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_data))
endmodule

>>> bench/tx_cell_pdr_relocation_tracker_core_tb.sv
// Self-checking testbench for the transmit-cell delivery-ratio tracker.
`timescale 1ns / 100ps

// Holds the tracker's expected state and the queue of results still owed.
class tcprt_cell_table;
    logic [15:0] slot_q[16];
    logic [7:0]  chan_q[16];
    logic [7:0]  tx_q[16];
    logic [7:0]  ack_q[16];
    int unsigned total;
    int unsigned min_tx;
    int unsigned margin;
    tcprt_pkg::t_out_item owed[$];
    int mismatch_count;
    int checked_count;

    function new();
        total = 0;
        min_tx = 128;
        margin = 50;
        mismatch_count = 0;
        checked_count = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [7:0] val);
        if (idx == tcprt_pkg::CFG_MIN_TX) begin
            min_tx = val;
        end else begin
            margin = val & 8'h7F;
        end
    endfunction

    // Updates the table for one accepted item and queues the result it owes.
    function void note_item(tcprt_pkg::t_in_item it);
        tcprt_pkg::t_out_item r;
        int unsigned pos, k, cur, att, start, best, worst, widx, ratio;
        bit hit, any;
        r = '0;
        case (it.func)
            tcprt_pkg::FUNC_ADD: begin
                if (total >= 16) begin
                    r.status = tcprt_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < total && slot_q[pos] >= it.slot) pos++;
                    for (k = total; k > pos; k--) begin
                        slot_q[k] = slot_q[k-1]; chan_q[k] = chan_q[k-1];
                        tx_q[k] = tx_q[k-1]; ack_q[k] = ack_q[k-1];
                    end
                    slot_q[pos] = it.slot; chan_q[pos] = it.chan;
                    tx_q[pos] = 0; ack_q[pos] = 0;
                    total++;
                end
            end
            tcprt_pkg::FUNC_REMOVE: begin
                r.status = tcprt_pkg::ST_NOTFOUND;
                for (pos = 0; pos < total; pos++) begin
                    if (slot_q[pos] == it.slot && chan_q[pos] == it.chan) begin
                        for (k = pos; k + 1 < total; k++) begin
                            slot_q[k] = slot_q[k+1]; chan_q[k] = chan_q[k+1];
                            tx_q[k] = tx_q[k+1]; ack_q[k] = ack_q[k+1];
                        end
                        total--;
                        r.status = tcprt_pkg::ST_OK;
                        break;
                    end
                end
            end
            tcprt_pkg::FUNC_REPORT: begin
                att = it.tx_attempts;
                hit = 0;
                start = 0;
                for (pos = 0; pos < total; pos++) begin
                    if (slot_q[pos] <= it.slot) begin
                        start = pos; hit = 1; break;
                    end
                end
                if (total == 0 || (!hit && att <= 1)) begin
                    r.status = tcprt_pkg::ST_NOTFOUND;
                end else begin
                    if (!hit) att--;
                    if (it.tx_acked && ack_q[start] != 8'd255) ack_q[start]++;
                    cur = start;
                    for (k = 0; k < att; k++) begin
                        if (tx_q[cur] == 8'd255) begin
                            tx_q[cur] = 8'd128;
                            ack_q[cur] = ack_q[cur] >> 1;
                        end else begin
                            tx_q[cur]++;
                        end
                        cur++;
                        if (cur >= total) cur = 0;
                    end
                end
            end
            tcprt_pkg::FUNC_PROPOSE: begin
                any = 0; best = 0; worst = 0; widx = 0;
                for (pos = 0; pos < total; pos++) begin
                    if (tx_q[pos] == 0 || tx_q[pos] < min_tx) continue;
                    ratio = (ack_q[pos] * 100) / tx_q[pos];
                    if (!any || ratio > best) best = ratio;
                    if (!any || ratio < worst) begin
                        worst = ratio; widx = pos;
                    end
                    any = 1;
                end
                if (any && best - worst > margin) begin
                    r.found = 1'b1;
                    r.cell_slot = slot_q[widx];
                    r.cell_channel = chan_q[widx];
                end
            end
            tcprt_pkg::FUNC_CLEAR: total = 0;
            default: ;
        endcase
        r.cell_count = total[4:0];
        owed.push_back(r);
    endfunction

    function void check_result(tcprt_pkg::t_out_item got);
        tcprt_pkg::t_out_item want;
        checked_count++;
        if (owed.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", got);
            return;
        end
        want = owed.pop_front();
        if (got.status !== want.status || got.found !== want.found
            || got.cell_slot !== want.cell_slot || got.cell_channel !== want.cell_channel
            || got.cell_count !== want.cell_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Result %0d: expected st=%0d fd=%0d sl=%h ch=%h n=%0d",
                         checked_count, want.status, want.found, want.cell_slot,
                         want.cell_channel, want.cell_count);
                $display("            actual   st=%0d fd=%0d sl=%h ch=%h n=%0d",
                         got.status, got.found, got.cell_slot, got.cell_channel,
                         got.cell_count);
            end
        end
    endfunction
endclass

module tx_cell_pdr_relocation_tracker_core_tb;
    import tcprt_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_data;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    tcprt_cell_table table_model;
    int          idle_cycles;
    bit          stall_enable;
    int          sent_count;
    logic [15:0] used_slots[$];

    // The watchdog allows far more than the work of the slowest transfer
    // plus the longest output stall.
    localparam int WatchdogLimit = 20000;

    tx_cell_pdr_relocation_tracker_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, with the occasional long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // The receiving side: stalls at random while enabled, and checks every transfer.
    initial begin
        int hold;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) table_model.check_result(out_data);
            if (hold > 0) begin
                hold--;
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                hold = gap_length();
            end
            out_stall <= (hold > 0);
        end
    end

    // Counts cycles in which no transfer of either channel takes place.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("Watchdog expired with %0d results outstanding", table_model.owed.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Presents one item and holds it until the block takes the transfer.
    task automatic send_item(t_in_item it, bit with_gap);
        int g;
        if (with_gap) begin
            g = gap_length();
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        table_model.note_item(it);
        sent_count++;
        in_valid <= 1'b0;
        // The block stalls its input right after taking a transfer, so this edge costs nothing.
        @(posedge clk);
    endtask

    task automatic send_op(logic [2:0] f, logic [15:0] s, logic [7:0] c,
                           logic [7:0] a, logic k, bit with_gap);
        t_in_item it;
        it.func = f; it.slot = s; it.chan = c;
        it.tx_attempts = a; it.tx_acked = k;
        send_item(it, with_gap);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        while (table_model.owed.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        table_model.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A random item, biased towards cells that exist so that removes and reports land.
    task automatic random_item();
        int sel;
        logic [15:0] s;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        s = (used_slots.size() != 0 && $urandom_range(0, 1))
            ? used_slots[$urandom_range(0, used_slots.size() - 1)] : 16'($urandom);
        c = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) c = 8'($urandom);
        if (sel < 22) begin
            if (used_slots.size() < 40) used_slots.push_back(s);
            send_op(FUNC_ADD, s, c, 8'($urandom), 1'($urandom), 1'b1);
        end else if (sel < 34) begin
            send_op(FUNC_REMOVE, s, c, 8'($urandom), 1'($urandom), 1'b1);
        end else if (sel < 80) begin
            send_op(FUNC_REPORT, s, 8'($urandom),
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)),
                    ($urandom_range(0, 3) != 0), 1'b1);
        end else if (sel < 93) begin
            send_op(FUNC_PROPOSE, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
        end else if (sel < 96) begin
            send_op(FUNC_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
            used_slots.delete();
        end else begin
            send_op(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 1'b1);
        end
    endtask

    initial begin
        table_model = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MIN_TX;
        cfg_data     = '0;
        stall_enable = 1'b0;
        sent_count   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values: empty-table cases first.
        send_op(FUNC_REPORT, 16'hFFFF, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_op(FUNC_REMOVE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_PROPOSE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        // Extremes of slot and channel, and equal slots landing after each other.
        send_op(FUNC_ADD, 16'hFFFF, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_ADD, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_ADD, 16'h8000, 8'h55, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_ADD, 16'h8000, 8'hAA, 8'h00, 1'b0, 1'b0);
        // No entry at or below the slot cannot happen with slot 0 present, so remove it.
        send_op(FUNC_REMOVE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_REMOVE, 16'h1234, 8'h00, 8'h00, 1'b0, 1'b0);
        send_op(FUNC_REPORT, 16'h0001, 8'h00, 8'h01, 1'b1, 1'b0);
        send_op(FUNC_REPORT, 16'h0001, 8'h00, 8'h00, 1'b1, 1'b0);
        send_op(FUNC_REPORT, 16'h0001, 8'h00, 8'hFF, 1'b1, 1'b0);
        // Long walks drive the transmit counters past 255 so they wrap to 128.
        send_op(FUNC_REPORT, 16'hFFFF, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_op(FUNC_REPORT, 16'h8000, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_op(FUNC_REPORT, 16'h9000, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_op(FUNC_PROPOSE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        send_op(3'd7, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_op(3'd5, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 15; i++) begin
            send_op(FUNC_ADD, 16'(i * 4000), 8'(i), 8'h00, 1'b0, 1'b0);
        end
        drain();

        // A phase per register setting, extremes included; stalls are enabled from here.
        stall_enable = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_MIN_TX, 8'd0);   write_reg(CFG_MARGIN, 8'd0);   end
                1: begin write_reg(CFG_MIN_TX, 8'd255); write_reg(CFG_MARGIN, 8'd100); end
                2: begin write_reg(CFG_MIN_TX, 8'd1);   write_reg(CFG_MARGIN, 8'd10);  end
                3: begin write_reg(CFG_MIN_TX, 8'd20);  write_reg(CFG_MARGIN, 8'd30);  end
                4: begin write_reg(CFG_MIN_TX, 8'd128); write_reg(CFG_MARGIN, 8'd50);  end
                default: begin
                    write_reg(CFG_MIN_TX, 8'($urandom_range(0, 60)));
                    write_reg(CFG_MARGIN, 8'($urandom_range(0, 100)));
                end
            endcase
            for (int i = 0; i < 315; i++) begin
                random_item();
                // Stretches with no output stalls, and one full pause of the sender.
                if (i == 100) stall_enable = 1'b0;
                if (i == 160) stall_enable = 1'b1;
                if (i == 200) begin
                    while (table_model.owed.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        stall_enable = 1'b0;
        drain();
        $display("Ran %0d items over six register settings: add, remove, report, propose,",
                 sent_count);
        $display("clear and unused codes, with %0d results checked.", table_model.checked_count);
        if (table_model.mismatch_count == 0 && table_model.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> tx_cell_pdr_relocation_tracker_core.f
+incdir+rtl
rtl/tcprt_pkg.sv
rtl/tcprt_div.sv
rtl/tx_cell_pdr_relocation_tracker_core.sv
bench/tx_cell_pdr_relocation_tracker_core_tb.sv
